>>> src/tmf_pkg.sv
// types, codes and default constants shared by the terminated message fifo
// no dependencies; imported by tmf_ctrl, tmf_datapath and the top level
package tmf_pkg;

    localparam int MSG_BYTES_DEF = 32;
    localparam int SLOTS_DEF = 4;
    localparam logic [7:0] END_SYMBOL_RST = 8'd3;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_LEN_EXCESS = 2'd1,
        ST_EMPTY      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        FS_EMPTY  = 2'd0,
        FS_FILLED = 2'd1,
        FS_FULL   = 2'd2
    } t_fifo_state;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_ctl_state;

    typedef struct packed {
        logic        kind;
        logic [7:0]  rx_byte;
        logic [15:0] request_length;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [6:0]  msg_length;
        logic [7:0]  data_byte;
        logic        last;
    } t_res;

    typedef struct packed {
        logic byte_wr;
        logic emit_len_err;
        logic emit_empty_err;
        logic emit_null_read;
        logic read_begin;
        logic read_step;
    } t_dp_ctl;

    typedef struct packed {
        logic fifo_full;
        logic ring_vacant;
        logic len_excess;
        logic slot_empty;
        logic read_last;
    } t_dp_sts;

endpackage

>>> src/tmf_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module tmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/tmf_ctrl.sv
// request sequencer: decodes accepted requests and steps message reads
// depends on tmf_pkg
module tmf_ctrl
    import tmf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_kind,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl,
    output logic    o_busy
);

    t_ctl_state r_state;
    t_ctl_state n_state;
    logic       accept;

    assign accept = i_start && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_kind == KIND_READ && !i_sts.len_excess
                        && !i_sts.ring_vacant && !i_sts.slot_empty) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (i_sts.read_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_BYTE) begin
                        o_ctl.byte_wr = !i_sts.fifo_full;
                    end else if (i_sts.len_excess) begin
                        o_ctl.emit_len_err = 1'b1;
                    end else if (i_sts.ring_vacant) begin
                        o_ctl.emit_empty_err = 1'b1;
                    end else if (i_sts.slot_empty) begin
                        o_ctl.emit_null_read = 1'b1;
                    end else begin
                        o_ctl.read_begin = 1'b1;
                    end
                end
            end
            S_READ: begin
                o_ctl.read_step = 1'b1;
            end
            default: o_ctl = '0;
        endcase
    end

    assign o_busy = (r_state == S_READ);

endmodule

>>> src/tmf_datapath.sv
// slot ring, fill and read pointers, message store and result register
// depends on tmf_pkg and tmf_ram
module tmf_datapath
    import tmf_pkg::*;
#(
    parameter int MSG_BYTES = MSG_BYTES_DEF,
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_req       i_req,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  t_dp_ctl    i_ctl,
    output t_dp_sts    o_sts,
    output logic       o_res_strobe,
    output t_res       o_res
);

    localparam int LW = $clog2(MSG_BYTES + 1);
    localparam int PW = $clog2(MSG_BYTES);
    localparam int SW = $clog2(SLOTS);
    localparam int AW = SW + PW;
    localparam int DEPTH = SLOTS << PW;

    logic [7:0]    r_end_symbol, n_end_symbol;
    logic [LW-1:0] r_slot_len [SLOTS];
    logic [LW-1:0] n_slot_len [SLOTS];
    logic [SW-1:0] r_wr_slot, n_wr_slot;
    logic [SW-1:0] r_rd_slot, n_rd_slot;
    logic [LW-1:0] r_fill, n_fill;
    t_fifo_state   r_fifo_state, n_fifo_state;
    logic [LW-1:0] r_rd_idx, n_rd_idx;
    logic [LW-1:0] r_rd_len, n_rd_len;
    logic          r_out_vld, n_out_vld;
    t_status       r_out_status, n_out_status;
    logic [LW-1:0] r_out_len, n_out_len;
    logic          r_out_last, n_out_last;
    logic          r_out_ram, n_out_ram;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [SW-1:0] wr_next;
    logic [SW-1:0] rd_next;
    logic [LW-1:0] cur_len;
    logic          close_slot;
    logic          free_slot;

    tmf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_req.rx_byte),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign wr_next = (r_wr_slot == SW'(SLOTS - 1)) ? '0 : r_wr_slot + 1'b1;
    assign rd_next = (r_rd_slot == SW'(SLOTS - 1)) ? '0 : r_rd_slot + 1'b1;
    assign cur_len = r_slot_len[r_rd_slot];
    assign ram_waddr = {r_wr_slot, r_fill[PW-1:0]};
    assign ram_raddr = {r_rd_slot, r_rd_idx[PW-1:0]};

    always_comb begin
        o_sts.fifo_full   = (r_fifo_state == FS_FULL);
        o_sts.ring_vacant = (r_fifo_state == FS_EMPTY);
        o_sts.len_excess  = (i_req.request_length > 16'(MSG_BYTES));
        o_sts.slot_empty  = (cur_len == '0);
        o_sts.read_last   = (r_rd_idx == r_rd_len - LW'(1));
    end

    always_comb begin
        n_end_symbol = r_end_symbol;
        n_slot_len   = r_slot_len;
        n_wr_slot    = r_wr_slot;
        n_rd_slot    = r_rd_slot;
        n_fill       = r_fill;
        n_fifo_state = r_fifo_state;
        n_rd_idx     = r_rd_idx;
        n_rd_len     = r_rd_len;
        n_out_vld    = 1'b0;
        n_out_status = ST_OK;
        n_out_len    = '0;
        n_out_last   = 1'b1;
        n_out_ram    = 1'b0;
        ram_we       = 1'b0;
        close_slot   = 1'b0;
        free_slot    = 1'b0;

        if (i_cfg_we) begin
            n_end_symbol = i_cfg_wdata;
        end

        if (i_ctl.byte_wr) begin
            if (r_fill < LW'(MSG_BYTES)) begin
                ram_we = 1'b1;
                n_fill = r_fill + 1'b1;
                n_slot_len[r_wr_slot] = r_fill + 1'b1;
                close_slot = (i_req.rx_byte == r_end_symbol);
            end else begin
                n_slot_len[r_wr_slot] = LW'(MSG_BYTES);
                close_slot = 1'b1;
            end
        end

        if (i_ctl.emit_len_err) begin
            n_out_vld    = 1'b1;
            n_out_status = ST_LEN_EXCESS;
        end
        if (i_ctl.emit_empty_err) begin
            n_out_vld    = 1'b1;
            n_out_status = ST_EMPTY;
        end
        if (i_ctl.emit_null_read) begin
            n_out_vld = 1'b1;
            free_slot = 1'b1;
        end
        if (i_ctl.read_begin) begin
            n_rd_idx = '0;
            n_rd_len = cur_len;
        end
        if (i_ctl.read_step) begin
            n_out_vld  = 1'b1;
            n_out_len  = r_rd_len;
            n_out_last = o_sts.read_last;
            n_out_ram  = 1'b1;
            n_rd_idx   = r_rd_idx + 1'b1;
            free_slot  = o_sts.read_last;
        end

        if (close_slot) begin
            n_wr_slot    = wr_next;
            n_fill       = '0;
            n_fifo_state = (wr_next == r_rd_slot) ? FS_FULL : FS_FILLED;
        end
        if (free_slot) begin
            n_slot_len[r_rd_slot] = '0;
            n_rd_slot    = rd_next;
            n_fifo_state = (rd_next == r_wr_slot) ? FS_EMPTY : FS_FILLED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_symbol <= END_SYMBOL_RST;
            for (int i = 0; i < SLOTS; i++) begin
                r_slot_len[i] <= '0;
            end
            r_wr_slot    <= '0;
            r_rd_slot    <= '0;
            r_fill       <= '0;
            r_fifo_state <= FS_EMPTY;
            r_out_vld    <= 1'b0;
        end else begin
            r_end_symbol <= n_end_symbol;
            r_slot_len   <= n_slot_len;
            r_wr_slot    <= n_wr_slot;
            r_rd_slot    <= n_rd_slot;
            r_fill       <= n_fill;
            r_fifo_state <= n_fifo_state;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_rd_len     <= n_rd_len;
        r_out_status <= n_out_status;
        r_out_len    <= n_out_len;
        r_out_last   <= n_out_last;
        r_out_ram    <= n_out_ram;
    end

    always_comb begin
        o_res_strobe     = r_out_vld;
        o_res.status     = r_out_status;
        o_res.msg_length = 7'(r_out_len);
        o_res.data_byte  = r_out_ram ? ram_rdata : 8'd0;
        o_res.last       = r_out_last;
    end

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_state == FS_EMPTY |-> r_rd_slot == r_wr_slot)
        else $error("empty fifo with differing slot pointers");

    a_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_state == FS_FULL |-> (r_rd_slot == r_wr_slot && r_fill == '0))
        else $error("full fifo with open write slot");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LW'(MSG_BYTES))
        else $error("fill position beyond slot size");

    a_step_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.read_step |=> (r_out_vld && r_out_ram))
        else $error("read step without result strobe");

endmodule

>>> src/terminated_message_fifo_core.sv
// top level of the terminated message fifo: sequencer plus datapath
// depends on tmf_pkg, tmf_ctrl, tmf_datapath (which holds tmf_ram)
//
// channel   direction  handshake                       payload
// request   in         start & !busy                   i_req (t_req)
// result    out        o_res_strobe, one cycle         o_res (t_res)
// config    in         i_cfg_we                        i_cfg_wdata (end symbol)
//
// a received byte leaves busy low and makes no result
// a read that errors or finds an empty slot leaves busy low; its result is
// strobed in the cycle after the request
// a good read holds busy high while the store is read one byte per cycle; the request
// loads the read index and length, then each read step registers one result
// reset is synchronous, clears the slot pointers, fill position and slot lengths and restores the end symbol
// results cannot be stalled by the receiver
module terminated_message_fifo_core
    import tmf_pkg::*;
#(
    parameter int MSG_BYTES = MSG_BYTES_DEF,
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output logic       o_res_strobe,
    output t_res       o_res
);

    t_dp_ctl ctl;
    t_dp_sts sts;

    tmf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_req.kind),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    tmf_datapath #(
        .MSG_BYTES (MSG_BYTES),
        .SLOTS     (SLOTS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

endmodule
